// ===== hdl/lxg_pkg.sv =====
// Shared constants, types and the word mixing function of the lagged xorshift generator.
package lxg_pkg;

    localparam int HISTORY_WORDS = 16;
    localparam int WORD_W        = 32;
    localparam int SLOT_W        = 4;

    localparam int OLD_LSHIFT = 5;
    localparam int OLD_RSHIFT = 3;
    localparam int NEW_RSHIFT = 4;

    typedef enum logic [0:0] {
        REQ_SEED = 1'b0,
        REQ_GEN  = 1'b1
    } req_t;

    typedef logic [WORD_W-1:0] word_t;

    // Command from the top level to the history register file.
    typedef struct packed {
        logic                gen;
        logic                seed_we;
        logic [SLOT_W-1:0]   slot;
        word_t               seed;
    } hist_cmd_t;

    // Combines the oldest and the newest history word into the next word.
    function automatic word_t lxg_mix(input word_t oldest, input word_t newest);
        word_t t;
        word_t w;
        t = oldest ^ (oldest << OLD_LSHIFT);
        t = t ^ (t >> OLD_RSHIFT);
        w = newest ^ (newest >> NEW_RSHIFT);
        return t ^ w;
    endfunction

endpackage

// ===== hdl/lxg_history.sv =====
// History shift line of the lagged xorshift generator with seed writes and the mixing step.
module lxg_history (
    input  logic               clk,
    input  logic               rst_n,
    input  lxg_pkg::hist_cmd_t cmd,
    output lxg_pkg::word_t     next_word
);

    lxg_pkg::word_t hist_reg  [lxg_pkg::HISTORY_WORDS];
    lxg_pkg::word_t hist_next [lxg_pkg::HISTORY_WORDS];

    // Slot 0 is the newest word and the last slot the oldest; both are fixed taps.
    assign next_word = lxg_pkg::lxg_mix(hist_reg[lxg_pkg::HISTORY_WORDS-1], hist_reg[0]);

    for (genvar k = 0; k < lxg_pkg::HISTORY_WORDS; k++) begin : g_lane
        always_comb
        begin
            hist_next[k] = hist_reg[k];
            if (cmd.gen)
            begin
                if (k == 0)
                begin
                    hist_next[k] = next_word;
                end
                else
                begin
                    hist_next[k] = hist_reg[(k == 0) ? 0 : k-1];
                end
            end
            else if (cmd.seed_we && (int'(cmd.slot) == k))
            begin
                hist_next[k] = cmd.seed;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hist_reg[k] <= '0;
            end
            else
            begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

endmodule

// ===== hdl/lagged_xorshift_generator.sv =====
// Top level of the lagged xorshift generator: input handshake, history and result buffer.
//
// The generator keeps a history of sixteen 32-bit words. A generate transfer mixes the
// oldest and the newest word into a new word, which is returned as random_word and becomes
// the newest history word while the oldest is dropped. A seed transfer writes seed_word
// into the history slot slot_index (0 newest) and returns nothing. After reset the history
// is all zeros and the generator returns zeros until it is seeded; the customary warm-up
// draws after seeding are issued by the user, whose results are discarded. The mixing step
// is a few levels of XOR between the history registers and the result register, so one
// transfer is accepted per cycle while in_stall is low; a generate result is registered in
// the output register, or in the skid register if the output holds a waiting result. This
// two-entry result buffer sits between the sides, so input transfers keep being taken while
// one result waits; in_stall rises only when both entries are full.
module lagged_xorshift_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [lxg_pkg::SLOT_W-1:0]    slot_index,
    input  logic [lxg_pkg::WORD_W-1:0]    seed_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lxg_pkg::WORD_W-1:0]    random_word
);

    lxg_pkg::hist_cmd_t cmd;
    lxg_pkg::word_t     next_word;

    logic           in_fire;
    logic           push;
    logic           pop;

    logic           out_valid_reg;
    logic           out_valid_next;
    lxg_pkg::word_t out_data_reg;
    lxg_pkg::word_t out_data_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    lxg_pkg::word_t skid_data_reg;
    lxg_pkg::word_t skid_data_next;

    // Input stalls only when the skid entry is occupied, which is a registered condition.
    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;

    assign cmd.gen     = in_fire && (req_type == lxg_pkg::REQ_GEN);
    assign cmd.seed_we = in_fire && (req_type == lxg_pkg::REQ_SEED);
    assign cmd.slot    = slot_index;
    assign cmd.seed    = seed_word;

    lxg_history u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .next_word (next_word)
    );

    assign push = cmd.gen;
    assign pop  = out_valid_reg && !out_stall;

    // The output register is the head of a two-entry queue and the skid register its tail.
    // A pop moves the tail forward; a push then fills the first free entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = next_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = next_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign random_word = out_data_reg;

`ifndef NO_ASSERTIONS
    // The tail entry is never occupied while the head entry is empty.
    a_skid_needs_head : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // A generate transfer always leaves a result on the output in the next cycle.
    a_gen_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == lxg_pkg::REQ_GEN)) |=> out_valid)
        else $error("generate transfer produced no result");

    // A generate transfer behind a stalled result must land in the skid entry.
    a_gen_into_skid : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == lxg_pkg::REQ_GEN)
         && out_valid && out_stall) |=> in_stall)
        else $error("result behind a stalled output was not buffered");
`endif

endmodule
